### src/vbm_pkg.sv
// Shared types and constants of the 3x3x3 volume box mean filter.
package vbm_pkg;

    // Largest field extents along each axis
    localparam int MAX_X = 32;
    localparam int MAX_Y = 32;
    localparam int MAX_Z = 32;

    // Field and register widths
    localparam int SZ_W   = 6;
    localparam int VAL_W  = 16;
    localparam int CRD_W  = 5;
    localparam int POS_W  = 16;
    localparam int PLN_W  = 11;
    localparam int SUM_W  = 21;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 2;

    // Voxel history ring: power of two above twice the largest lag
    localparam int HIST_DEPTH = 4096;
    localparam int ADDR_W     = 12;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    // Input item kinds
    localparam logic KIND_VOXEL = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET1,
        S_SET2,
        S_READ,
        S_DRAIN,
        S_DINIT,
        S_DIV,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic cfg_we;
        logic clr_acc;
        logic rd_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic ready;
        logic rd_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### src/vbm_ram.sv
// Generic simple dual-port RAM with registered read.
module vbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/vbm_ctrl.sv
// Controller state machine of the volume box mean filter.
module vbm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  vbm_pkg::t_stat i_stat,
    output vbm_pkg::t_cmd  o_cmd,
    output logic          o_in_stall,
    output logic          o_cfg_ready
);

    vbm_pkg::t_state r_state, n_state;
    logic            in_acc;
    logic            cfg_acc;

    // Configuration takes priority over items in idle
    assign cfg_acc = (r_state == vbm_pkg::S_IDLE) && i_cfg_valid;
    assign in_acc  = (r_state == vbm_pkg::S_IDLE) && !i_cfg_valid && i_in_valid;

    assign o_cfg_ready = (r_state == vbm_pkg::S_IDLE);
    assign o_in_stall  = (r_state != vbm_pkg::S_IDLE) || i_cfg_valid;

    // State register; reset waits for derived sizes to settle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbm_pkg::S_SET1;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            vbm_pkg::S_IDLE: begin
                o_cmd.cfg_we = cfg_acc;
                o_cmd.accept = in_acc;
                if (cfg_acc) begin
                    n_state = vbm_pkg::S_SET1;
                end else if (in_acc && i_stat.ready) begin
                    o_cmd.clr_acc = 1'b1;
                    n_state       = vbm_pkg::S_READ;
                end
            end
            vbm_pkg::S_SET1:  n_state = vbm_pkg::S_SET2;
            vbm_pkg::S_SET2:  n_state = vbm_pkg::S_IDLE;
            vbm_pkg::S_READ: begin
                o_cmd.rd_step = 1'b1;
                if (i_stat.rd_last) begin
                    n_state = vbm_pkg::S_DRAIN;
                end
            end
            vbm_pkg::S_DRAIN: n_state = vbm_pkg::S_DINIT;
            vbm_pkg::S_DINIT: begin
                o_cmd.div_start = 1'b1;
                n_state         = vbm_pkg::S_DIV;
            end
            vbm_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = vbm_pkg::S_OUT;
                end
            end
            vbm_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = vbm_pkg::S_IDLE;
                end
            end
            default: n_state = vbm_pkg::S_IDLE;
        endcase
    end

    a_read_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vbm_pkg::S_READ && i_stat.rd_last) |=> (r_state == vbm_pkg::S_DRAIN))
        else $error("read sweep did not end in drain");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cfg_we |=> (r_state == vbm_pkg::S_SET1))
        else $error("config write not followed by settle");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept || o_cmd.cfg_we) |-> (r_state == vbm_pkg::S_IDLE))
        else $error("transfer taken while busy");

endmodule

### src/vbm_dp.sv
// Datapath: sizes, positions, history ring, neighbor sum and divider.
module vbm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vbm_pkg::t_cmd               i_cmd,
    output vbm_pkg::t_stat              o_stat,
    input  logic [vbm_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [vbm_pkg::SZ_W-1:0]   i_cfg_data,
    input  logic                       i_in_kind,
    input  logic [vbm_pkg::VAL_W-1:0]  i_in_value,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic [vbm_pkg::VAL_W-1:0]  o_out_mean,
    output logic                       o_out_last
);

    logic [vbm_pkg::SZ_W-1:0]   r_size_x, r_size_y, r_size_z;
    logic [vbm_pkg::SZ_W-1:0]   sx, sy, sz;
    logic [vbm_pkg::PLN_W-1:0]  r_plane, r_lag;
    logic [vbm_pkg::POS_W-1:0]  r_total;
    logic [vbm_pkg::POS_W-1:0]  r_inpos, r_outpos;
    logic [vbm_pkg::CRD_W-1:0]  r_ox, r_oy, r_oz;
    logic [1:0]                 r_dx, r_dy, r_dz;
    logic                       r_rd_vld;
    logic [vbm_pkg::SUM_W-1:0]  r_acc, r_num;
    logic [vbm_pkg::CNT_W-1:0]  r_cnt, r_rem;
    logic [vbm_pkg::CNT_W-1:0]  r_bit;
    logic                       r_out_valid;
    logic [vbm_pkg::VAL_W-1:0]  r_mean;
    logic                       r_last;

    logic                       wr_ok;
    logic                       wr_en;
    logic [vbm_pkg::POS_W-1:0]  inpos_new;
    logic [vbm_pkg::POS_W-1:0]  inpos_next;
    logic [vbm_pkg::POS_W:0]    need_raw;
    logic [vbm_pkg::POS_W:0]    need;
    logic                       inb;
    logic [vbm_pkg::POS_W-1:0]  offx, offy, qaddr;
    logic [vbm_pkg::VAL_W-1:0]  ram_q;
    logic [vbm_pkg::CNT_W:0]    rem_sh;
    logic                       qbit;
    logic                       is_last;

    // Clamp sizes into range
    function automatic logic [vbm_pkg::SZ_W-1:0] eff(input logic [vbm_pkg::SZ_W-1:0] v,
                                                      input logic [vbm_pkg::SZ_W-1:0] m);
        logic [vbm_pkg::SZ_W-1:0] r;
        r = v;
        if (v == '0) r = vbm_pkg::SZ_W'(1);
        else if (v > m) r = m;
        return r;
    endfunction

    assign sx = eff(r_size_x, vbm_pkg::SZ_W'(vbm_pkg::MAX_X));
    assign sy = eff(r_size_y, vbm_pkg::SZ_W'(vbm_pkg::MAX_Y));
    assign sz = eff(r_size_z, vbm_pkg::SZ_W'(vbm_pkg::MAX_Z));

    // Derived extents, one multiply per stage
    always_ff @(posedge i_clk) begin
        r_plane <= vbm_pkg::PLN_W'(sy) * vbm_pkg::PLN_W'(sz);
        r_lag   <= r_plane + vbm_pkg::PLN_W'(sz) + vbm_pkg::PLN_W'(1);
        r_total <= vbm_pkg::POS_W'(sx) * vbm_pkg::POS_W'(r_plane);
    end

    // Item write and result readiness; readiness assumes the offered item is taken
    assign wr_ok      = (i_in_kind == vbm_pkg::KIND_VOXEL) && (r_inpos < r_total);
    assign wr_en      = i_cmd.accept && wr_ok;
    assign inpos_new  = wr_en ? r_inpos + vbm_pkg::POS_W'(1) : r_inpos;
    assign inpos_next = wr_ok ? r_inpos + vbm_pkg::POS_W'(1) : r_inpos;
    assign need_raw   = {1'b0, r_outpos} + (vbm_pkg::POS_W+1)'(r_lag) + (vbm_pkg::POS_W+1)'(1);
    assign need       = (need_raw > {1'b0, r_total}) ? {1'b0, r_total} : need_raw;
    assign o_stat.ready = (r_outpos < r_total) && ({1'b0, inpos_next} >= need);

    // Neighbor bounds and address
    always_comb begin
        inb = 1'b1;
        if (r_dx == 2'd0 && r_ox == '0) inb = 1'b0;
        if (r_dx == 2'd2 && ({1'b0, r_ox} + vbm_pkg::SZ_W'(1)) == sx) inb = 1'b0;
        if (r_dy == 2'd0 && r_oy == '0) inb = 1'b0;
        if (r_dy == 2'd2 && ({1'b0, r_oy} + vbm_pkg::SZ_W'(1)) == sy) inb = 1'b0;
        if (r_dz == 2'd0 && r_oz == '0) inb = 1'b0;
        if (r_dz == 2'd2 && ({1'b0, r_oz} + vbm_pkg::SZ_W'(1)) == sz) inb = 1'b0;
        case (r_dx)
            2'd0:    offx = '0;
            2'd1:    offx = vbm_pkg::POS_W'(r_plane);
            default: offx = vbm_pkg::POS_W'({r_plane, 1'b0});
        endcase
        case (r_dy)
            2'd0:    offy = '0;
            2'd1:    offy = vbm_pkg::POS_W'(sz);
            default: offy = vbm_pkg::POS_W'({sz, 1'b0});
        endcase
        qaddr = r_outpos + offx + offy + vbm_pkg::POS_W'(r_dz) - vbm_pkg::POS_W'(r_lag);
    end

    assign o_stat.rd_last = (r_dx == 2'd2) && (r_dy == 2'd2) && (r_dz == 2'd2);

    vbm_ram #(
        .WIDTH (vbm_pkg::VAL_W),
        .DEPTH (vbm_pkg::HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_inpos[vbm_pkg::ADDR_W-1:0]),
        .i_wdata (i_in_value),
        .i_raddr (qaddr[vbm_pkg::ADDR_W-1:0]),
        .o_rdata (ram_q)
    );

    // Restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[vbm_pkg::SUM_W-1]};
    assign qbit   = (rem_sh >= {1'b0, r_cnt});
    assign o_stat.div_last = (r_bit == '0);

    assign is_last       = (r_outpos == r_total - vbm_pkg::POS_W'(1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    // Sweep neighbors, accumulate, divide
    always_ff @(posedge i_clk) begin
        r_rd_vld <= i_cmd.rd_step && inb;
        if (i_cmd.clr_acc) begin
            r_dx  <= '0;
            r_dy  <= '0;
            r_dz  <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.rd_step) begin
                if (r_dz == 2'd2) begin
                    r_dz <= '0;
                    if (r_dy == 2'd2) begin
                        r_dy <= '0;
                        r_dx <= r_dx + 2'd1;
                    end else begin
                        r_dy <= r_dy + 2'd1;
                    end
                end else begin
                    r_dz <= r_dz + 2'd1;
                end
                if (inb) begin
                    r_cnt <= r_cnt + vbm_pkg::CNT_W'(1);
                end
            end
            if (r_rd_vld) begin
                r_acc <= r_acc + vbm_pkg::SUM_W'(ram_q);
            end
        end
        if (i_cmd.div_start) begin
            r_num <= r_acc + vbm_pkg::SUM_W'(r_cnt >> 1);
            r_rem <= '0;
            r_bit <= vbm_pkg::CNT_W'(vbm_pkg::SUM_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? vbm_pkg::CNT_W'(rem_sh - {1'b0, r_cnt}) : rem_sh[vbm_pkg::CNT_W-1:0];
            r_num <= {r_num[vbm_pkg::SUM_W-2:0], qbit};
            r_bit <= r_bit - vbm_pkg::CNT_W'(1);
        end
    end

    // Hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean <= r_num[vbm_pkg::VAL_W-1:0];
            r_last <= is_last;
        end
    end

    // Control registers: sizes, positions, coordinates, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x    <= vbm_pkg::SZ_W'(8);
            r_size_y    <= vbm_pkg::SZ_W'(8);
            r_size_z    <= vbm_pkg::SZ_W'(8);
            r_inpos     <= '0;
            r_outpos    <= '0;
            r_ox        <= '0;
            r_oy        <= '0;
            r_oz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.cfg_we) begin
                unique case (i_cfg_index)
                    vbm_pkg::REG_SIZE_X: r_size_x <= i_cfg_data;
                    vbm_pkg::REG_SIZE_Y: r_size_y <= i_cfg_data;
                    vbm_pkg::REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index == vbm_pkg::REG_SIZE_X || i_cfg_index == vbm_pkg::REG_SIZE_Y ||
                    i_cfg_index == vbm_pkg::REG_SIZE_Z) begin
                    r_inpos  <= '0;
                    r_outpos <= '0;
                    r_ox     <= '0;
                    r_oy     <= '0;
                    r_oz     <= '0;
                end
            end else if (i_cmd.out_load && is_last) begin
                r_inpos  <= '0;
                r_outpos <= '0;
                r_ox     <= '0;
                r_oy     <= '0;
                r_oz     <= '0;
            end else begin
                r_inpos <= inpos_new;
                if (i_cmd.out_load) begin
                    r_outpos <= r_outpos + vbm_pkg::POS_W'(1);
                    if ({1'b0, r_oz} + vbm_pkg::SZ_W'(1) == sz) begin
                        r_oz <= '0;
                        if ({1'b0, r_oy} + vbm_pkg::SZ_W'(1) == sy) begin
                            r_oy <= '0;
                            r_ox <= r_ox + vbm_pkg::CRD_W'(1);
                        end else begin
                            r_oy <= r_oy + vbm_pkg::CRD_W'(1);
                        end
                    end else begin
                        r_oz <= r_oz + vbm_pkg::CRD_W'(1);
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_mean  = r_mean;
    assign o_out_last  = r_last;

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("divide by zero neighbor count");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outpos <= r_inpos)
        else $error("result position ahead of input position");

endmodule

### src/volume_box_mean_3x3x3.sv
// Top level of the 3x3x3 volume box mean filter.
// Voxels enter on the input channel in raster order (x slowest, z fastest),
// kind 0 carrying a value, kind 1 a flush item without data. Each result is
// the rounded mean of the voxel and its in-bounds 3x3x3 neighbors, given in
// raster order on the output channel with last set on the final voxel.
// A result appears once the voxels one plane, one row and one voxel ahead
// have arrived; after the last voxel, flush items push out the rest.
// Sizes are set through the config channel (index 0..2 = x, y, z); any size
// write restarts the field and blocks items in the settle states SET1 and
// SET2 while extents settle.
// An item that yields no result leaves the block idle. An item that yields
// one goes through the transfer, a sweep of the 27 neighbors through the
// single read port of the history RAM, one drain and one divider setup step,
// a bit-serial restoring divider and the load of the output register.
// The result waits in an output register, so the next item is taken while
// a stalled result is held; a further result waits for that register.
// Reset sets sizes to 8x8x8, clears positions and passes through SET1 and SET2.
module volume_box_mean_3x3x3 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_in_kind,
    input  logic [vbm_pkg::VAL_W-1:0]  i_in_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [vbm_pkg::VAL_W-1:0]  o_out_mean,
    output logic                       o_out_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [vbm_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [vbm_pkg::SZ_W-1:0]   i_cfg_data
);

    vbm_pkg::t_cmd  cmd;
    vbm_pkg::t_stat stat;

    vbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    vbm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_kind   (i_in_kind),
        .i_in_value  (i_in_value),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_mean  (o_out_mean),
        .o_out_last  (o_out_last)
    );

endmodule
